@@ rtl/atc_pkg.sv @@
package atc_pkg;
  localparam int MAX_STAGES = 24;
  localparam int ZW = 34;
  localparam int XW = 28;
  localparam logic signed [ZW-1:0] DEG90 = 34'sd754974720;
  localparam logic signed [ZW-1:0] ATAN_TAB [MAX_STAGES] = '{
    34'sd377487360, 34'sd222843801, 34'sd117744544, 34'sd59768969,
    34'sd30000467, 34'sd15014858, 34'sd7509261, 34'sd3754860,
    34'sd1877459, 34'sd938733, 34'sd469367, 34'sd234683,
    34'sd117342, 34'sd58671, 34'sd29335, 34'sd14668,
    34'sd7334, 34'sd3667, 34'sd1833, 34'sd917,
    34'sd458, 34'sd229, 34'sd115, 34'sd57
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [14:0] gx;
    logic signed [14:0] gy;
    logic signed [14:0] gz;
  } side_t;

  function automatic logic signed [14:0] gyro_scale(input logic signed [15:0] raw);
    logic [22:0] mag;
    logic [31:0] q;
    logic signed [15:0] qs;
    mag = raw[15] ? 23'(-(23'(signed'(raw)) <<< 6)) : 23'({raw, 6'd0});
    // divide by 131 via reciprocal: floor(v*m/2^k), checked with correction
    q = 32'((40'(mag + 23'd65) * 40'd32017) >> 22);
    if (32'(q * 131) > 32'(mag + 23'd65)) q = q - 1;
    else if (32'((q + 1) * 131) <= 32'(mag + 23'd65)) q = q + 1;
    qs = raw[15] ? -16'(q) : 16'(q);
    return qs[14:0];
  endfunction
endpackage

@@ rtl/accel_tilt_angle_cordic_unit.sv @@
// Tilt-angle unit for one six-axis inertial frame per item.
// Input: pulse start with the six raw samples; busy is always low, so a
// new item may be started in every cycle.
// Output: out_valid is high for one cycle with all eight result fields.
// Accelerometer values pass through; gyro values are rescaled to 1/64
// deg/s; roll = atan2(ay, az), pitch = atan2(-ax, sqrt(ay^2+az^2)) in
// 1/128 degree.
// Pipeline: an input register and a squaring register, then the 24 square-root
// cells (pitch needs the root), then both CORDIC chains of CORDIC_STAGES cells
// (capped at atc_pkg::MAX_STAGES) in parallel, then a rounding register.
// Throughput: one item per cycle, set by the chains of pipelined cells.
// Reset clears the valid pipeline only; payload stages are not reset.
// The receiver cannot stall: each result shows for exactly one cycle.
module accel_tilt_angle_cordic_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_accel_x_raw,
  input  logic signed [15:0] in_accel_y_raw,
  input  logic signed [15:0] in_accel_z_raw,
  input  logic signed [15:0] in_gyro_x_raw,
  input  logic signed [15:0] in_gyro_y_raw,
  input  logic signed [15:0] in_gyro_z_raw,
  output logic               out_valid,
  output logic signed [15:0] out_accel_x_g,
  output logic signed [15:0] out_accel_y_g,
  output logic signed [15:0] out_accel_z_g,
  output logic signed [14:0] out_gyro_x_rate,
  output logic signed [14:0] out_gyro_y_rate,
  output logic signed [14:0] out_gyro_z_rate,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_roll_angle
);
  localparam int NS = (CORDIC_STAGES > atc_pkg::MAX_STAGES) ? atc_pkg::MAX_STAGES :
                      CORDIC_STAGES;
  localparam int SQ = 24;
  localparam int LAT = 2 + SQ + NS + 1;
  localparam int XW = atc_pkg::XW;

  assign busy = 1'b0;

  // valid shift line
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[LAT-2:0], start};
  end
  assign out_valid = vld_r[LAT-1];

  // stage 0: register inputs, gyro scaling
  atc_pkg::side_t s0_r;
  always_ff @(posedge clk) begin
    s0_r.ax <= in_accel_x_raw;
    s0_r.ay <= in_accel_y_raw;
    s0_r.az <= in_accel_z_raw;
    s0_r.gx <= atc_pkg::gyro_scale(in_gyro_x_raw);
    s0_r.gy <= atc_pkg::gyro_scale(in_gyro_y_raw);
    s0_r.gz <= atc_pkg::gyro_scale(in_gyro_z_raw);
  end

  // stage 1: squares (one multiplier each)
  atc_pkg::side_t s1_r;
  logic [31:0] sqy_r, sqz_r;
  always_ff @(posedge clk) begin
    s1_r <= s0_r;
    sqy_r <= 32'(32'(signed'(s0_r.ay)) * 32'(signed'(s0_r.ay)));
    sqz_r <= 32'(32'(signed'(s0_r.az)) * 32'(signed'(s0_r.az)));
  end

  // square-root chain on (ay^2+az^2) * 65536; payload rides along
  logic [47:0] rem_w [SQ+1];
  logic [23:0] root_w [SQ+1];
  logic [47:0] src_w [SQ+1];
  logic [56:0] pay_w [SQ+1];
  assign rem_w[0] = '0;
  assign root_w[0] = '0;
  // squares sum fits 32 bits; shifted left 16 it fills the 48-bit source
  assign src_w[0] = {32'(33'(sqy_r) + 33'(sqz_r)), 16'd0};
  assign pay_w[0] = {s1_r.ax, s1_r.ay, s1_r.az, 9'd0};

  genvar g;
  generate
    for (g = 0; g < SQ; g++) begin : g_sq
      atc_sqrt_cell u_sq (
        .clk(clk), .rem_in(rem_w[g]), .root_in(root_w[g]), .src_in(src_w[g]),
        .pay_in(pay_w[g]), .rem_out(rem_w[g+1]), .root_out(root_w[g+1]),
        .src_out(src_w[g+1]), .pay_out(pay_w[g+1])
      );
    end
  endgenerate

  // gyro side data delay to match
  logic [44:0] gy_d_r [LAT-3];
  always_ff @(posedge clk) begin
    gy_d_r[0] <= {s1_r.gx, s1_r.gy, s1_r.gz};
    for (int i = 1; i < LAT - 3; i++) gy_d_r[i] <= gy_d_r[i-1];
  end

  logic signed [15:0] ax_s, ay_s, az_s;
  assign ax_s = pay_w[SQ][56:41];
  assign ay_s = pay_w[SQ][40:25];
  assign az_s = pay_w[SQ][24:9];
  logic [23:0] den;
  assign den = root_w[SQ];

  // pre-rotation into right half plane
  function automatic atc_pkg::vec_t pre_rot(input logic signed [XW-1:0] x,
                                            input logic signed [XW-1:0] y,
                                            input logic zero);
    atc_pkg::vec_t v;
    v.x = x; v.y = y; v.z = '0; v.zero = zero;
    if (x[XW-1]) begin
      if (!y[XW-1]) begin v.x = y; v.y = -x; v.z = atc_pkg::DEG90; end
      else begin v.x = -y; v.y = x; v.z = -atc_pkg::DEG90; end
    end
    return v;
  endfunction

  atc_pkg::vec_t p_w [NS+1];
  atc_pkg::vec_t r_w [NS+1];
  logic signed [XW-1:0] pitch_y;
  assign pitch_y = -(XW'(ax_s) <<< 8);
  assign p_w[0] = pre_rot(XW'(signed'({1'b0, den})), pitch_y, (den == 0) && (ax_s == 0));
  assign r_w[0] = pre_rot(XW'(az_s) <<< 8, XW'(ay_s) <<< 8, (ay_s == 0) && (az_s == 0));

  logic [47:0] acc_d_r [NS];
  always_ff @(posedge clk) begin
    acc_d_r[0] <= {ax_s, ay_s, az_s};
    for (int i = 1; i < NS; i++) acc_d_r[i] <= acc_d_r[i-1];
  end

  generate
    for (g = 0; g < NS; g++) begin : g_cd
      atc_cell #(.IDX(g)) u_p (.clk(clk), .v_in(p_w[g]), .v_out(p_w[g+1]));
      atc_cell #(.IDX(g)) u_r (.clk(clk), .v_in(r_w[g]), .v_out(r_w[g+1]));
    end
  endgenerate

  function automatic logic signed [15:0] to_out(input logic signed [atc_pkg::ZW-1:0] z,
                                                input int lim, input logic zero);
    logic signed [atc_pkg::ZW:0] a;
    a = ((atc_pkg::ZW+1)'(z) + 35'sd32768) >>> 16;
    if (zero) a = '0;
    else if (a > lim) a = (atc_pkg::ZW+1)'(lim);
    else if (a < -lim) a = -(atc_pkg::ZW+1)'(lim);
    return a[15:0];
  endfunction

  always_ff @(posedge clk) begin
    {out_accel_x_g, out_accel_y_g, out_accel_z_g} <= acc_d_r[NS-1];
    {out_gyro_x_rate, out_gyro_y_rate, out_gyro_z_rate} <= gy_d_r[LAT-4];
    out_pitch_angle <= 15'(to_out(p_w[NS].z, 11520, p_w[NS].zero));
    out_roll_angle <= to_out(r_w[NS].z, 23040, r_w[NS].zero);
  end
endmodule

@@ rtl/atc_cell.sv @@
module atc_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  atc_pkg::vec_t  v_in,
  output atc_pkg::vec_t  v_out
);
  atc_pkg::vec_t v_r, v_nxt;
  always_comb begin
    v_nxt = v_in;
    if (!v_in.y[atc_pkg::XW-1]) begin
      v_nxt.x = v_in.x + (v_in.y >>> IDX);
      v_nxt.y = v_in.y - (v_in.x >>> IDX);
      v_nxt.z = v_in.z + atc_pkg::ATAN_TAB[IDX];
    end else begin
      v_nxt.x = v_in.x - (v_in.y >>> IDX);
      v_nxt.y = v_in.y + (v_in.x >>> IDX);
      v_nxt.z = v_in.z - atc_pkg::ATAN_TAB[IDX];
    end
  end
  always_ff @(posedge clk) v_r <= v_nxt;
  assign v_out = v_r;
endmodule

@@ rtl/atc_sqrt_cell.sv @@
// one restoring step of a 48-bit integer square root (24 result bits)
module atc_sqrt_cell (
  input  logic        clk,
  input  logic [47:0] rem_in,
  input  logic [23:0] root_in,
  input  logic [47:0] src_in,
  input  logic [56:0] pay_in,
  output logic [47:0] rem_out,
  output logic [23:0] root_out,
  output logic [47:0] src_out,
  output logic [56:0] pay_out
);
  logic [49:0] trial;
  logic [49:0] cur;
  logic [47:0] rem_nxt;
  logic [23:0] root_nxt;
  always_comb begin
    cur = {rem_in, src_in[47:46]};
    trial = {root_in, 2'b01};
    if (cur >= trial) begin
      rem_nxt = 48'(cur - trial);
      root_nxt = {root_in[22:0], 1'b1};
    end else begin
      rem_nxt = cur[47:0];
      root_nxt = {root_in[22:0], 1'b0};
    end
  end
  always_ff @(posedge clk) begin
    rem_out <= rem_nxt;
    root_out <= root_nxt;
    src_out <= {src_in[45:0], 2'b00};
    pay_out <= pay_in;
  end
endmodule

@@ rtl/atc_checker.sv @@
module atc_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic signed [14:0] out_pitch_angle,
  input logic signed [15:0] out_roll_angle
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_roll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_angle <= 16'sd23040 && out_roll_angle >= -16'sd23040))
    else $error("roll out of range");
  a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= 15'sd11520 && out_pitch_angle >= -15'sd11520))
    else $error("pitch out of range");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind accel_tilt_angle_cordic_unit atc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_pitch_angle(out_pitch_angle), .out_roll_angle(out_roll_angle)
);

@@ sim/accel_tilt_angle_cordic_unit_tb.sv @@
module accel_tilt_angle_cordic_unit_tb;

  localparam int STAGES      = 16;
  // 2 input regs + 24 root cells + CORDIC cells + rounding reg
  localparam int LATENCY     = 2 + 24 + STAGES + 1;
  localparam int N_RANDOM    = 900;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
  } frame_t;

  typedef struct {
    logic signed [15:0] ax, ay, az;
    logic signed [14:0] gx, gy, gz;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } tilt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_ax = '0, in_ay = '0, in_az = '0;
  logic signed [15:0] in_gx = '0, in_gy = '0, in_gz = '0;
  logic out_valid;
  logic signed [15:0] out_ax, out_ay, out_az;
  logic signed [14:0] out_gx, out_gy, out_gz, out_pitch;
  logic signed [15:0] out_roll;

  frame_t pending_frames[$];
  tilt_t  tilt_expected[$];
  int     total_frames;
  int     frames_sent;
  int     results_seen;
  int     mismatches;
  int     cycles;

  accel_tilt_angle_cordic_unit #(.CORDIC_STAGES(STAGES)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_accel_x_raw(in_ax), .in_accel_y_raw(in_ay), .in_accel_z_raw(in_az),
    .in_gyro_x_raw(in_gx), .in_gyro_y_raw(in_gy), .in_gyro_z_raw(in_gz),
    .out_valid(out_valid),
    .out_accel_x_g(out_ax), .out_accel_y_g(out_ay), .out_accel_z_g(out_az),
    .out_gyro_x_rate(out_gx), .out_gyro_y_rate(out_gy), .out_gyro_z_rate(out_gz),
    .out_pitch_angle(out_pitch), .out_roll_angle(out_roll)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------- predictor ----------------

  // raw * 64 / 131, rounded to nearest, symmetric about zero
  function automatic logic signed [14:0] rate_of(logic signed [15:0] raw);
    longint n, mag, q;
    n = longint'(raw) * 64;
    mag = (n < 0) ? -n : n;
    q = (mag + 65) / 131;
    if (n < 0) q = -q;
    return q[14:0];
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring CORDIC, angle of (x, y) in 2^-23 degree
  function automatic longint angle_of(longint x, longint y);
    longint z, t, dx, dy;
    z = 0;
    if (x < 0) begin
      // quarter-turn into the right half plane
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = longint'(atc_pkg::DEG90);
      end else begin
        x = -y; y = t; z = -longint'(atc_pkg::DEG90);
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atc_pkg::ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(atc_pkg::ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  // round half up to 1/128 degree, then clamp
  function automatic longint degrees_128(longint z, longint lim);
    longint a;
    a = (z + 32768) >>> 16;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a;
  endfunction

  function automatic tilt_t tilt_of(frame_t f);
    tilt_t r;
    longint ax, ay, az, den, p, rl;
    ax = f.ax; ay = f.ay; az = f.az;
    r.ax = f.ax; r.ay = f.ay; r.az = f.az;
    r.gx = rate_of(f.gx);
    r.gy = rate_of(f.gy);
    r.gz = rate_of(f.gz);
    den = root_floor(longint'(ay * ay + az * az) * 65536);
    p = 0;
    rl = 0;
    // all three accelerations zero: pitch is zero
    if (!(den == 0 && ax == 0)) p = degrees_128(angle_of(den, -ax * 256), 11520);
    // ay and az both zero: roll is zero
    if (!(ay == 0 && az == 0)) rl = degrees_128(angle_of(az * 256, ay * 256), 23040);
    r.pitch = p[14:0];
    r.roll = rl[15:0];
    return r;
  endfunction

  // ---------------- stimulus ----------------

  function automatic logic signed [15:0] any16();
    return 16'($urandom);
  endfunction

  // realistic magnitudes most often, some full range, some tiny, some zero
  function automatic logic signed [15:0] accel_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return any16();
    if (sel < 5) return 16'($urandom_range(0, 16) - 8);
    if (sel == 5) return 16'sd0;
    return 16'($urandom_range(0, 40000) - 20000);
  endfunction

  task automatic add_frame(int ax, int ay, int az, int gx, int gy, int gz);
    frame_t f;
    f.ax = 16'(ax); f.ay = 16'(ay); f.az = 16'(az);
    f.gx = 16'(gx); f.gy = 16'(gy); f.gz = 16'(gz);
    pending_frames.push_back(f);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    mismatches++;
    $display("mismatch item %0d %s: got %0d expected %0d", results_seen, field, got, want);
  endtask

  // ---------------- driver ----------------
  // phase by progress: sender idles 34%, then 86%, then not at all
  always @(posedge clk) begin
    int idle_pct;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        tilt_expected.push_back(tilt_of('{in_ax, in_ay, in_az, in_gx, in_gy, in_gz}));
        frames_sent++;
      end
      if (frames_sent < total_frames / 3) idle_pct = 34;
      else if (frames_sent < 2 * total_frames / 3) idle_pct = 86;
      else idle_pct = 0;
      if (start && busy) begin
        // hold the item until taken
      end else if (pending_frames.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        frame_t f;
        f = pending_frames.pop_front();
        start <= 1'b1;
        in_ax <= f.ax; in_ay <= f.ay; in_az <= f.az;
        in_gx <= f.gx; in_gy <= f.gy; in_gz <= f.gz;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    tilt_t e;
    if (rst_n && out_valid) begin
      if (tilt_expected.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = tilt_expected.pop_front();
        if (out_ax !== e.ax) report_mismatch("accel_x_g", out_ax, e.ax);
        if (out_ay !== e.ay) report_mismatch("accel_y_g", out_ay, e.ay);
        if (out_az !== e.az) report_mismatch("accel_z_g", out_az, e.az);
        if (out_gx !== e.gx) report_mismatch("gyro_x_rate", out_gx, e.gx);
        if (out_gy !== e.gy) report_mismatch("gyro_y_rate", out_gy, e.gy);
        if (out_gz !== e.gz) report_mismatch("gyro_z_rate", out_gz, e.gz);
        if (out_pitch !== e.pitch) report_mismatch("pitch_angle", out_pitch, e.pitch);
        if (out_roll !== e.roll) report_mismatch("roll_angle", out_roll, e.roll);
      end
      results_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    // directed frames: extremes, zeros, quadrants, half-turn roll
    add_frame(0, 0, 0, 0, 0, 0);
    add_frame(-32768, -32768, -32768, -32768, -32768, -32768);
    add_frame(32767, 32767, 32767, 32767, 32767, 32767);
    add_frame(0, 0, 16384, 131, -131, 1);
    add_frame(0, 0, -16384, 65, -65, 66);
    add_frame(0, 0, -32768, -66, 2, -2);
    add_frame(16384, 0, 0, 0, 0, 0);
    add_frame(-32768, 0, 0, 0, 0, 0);
    add_frame(32767, 0, 0, 0, 0, 0);
    add_frame(0, 16384, 0, 0, 0, 0);
    add_frame(0, -16384, 0, 0, 0, 0);
    add_frame(0, 1000, -1000, 1, -1, 0);
    add_frame(0, -1000, -1000, 0, 0, 0);
    add_frame(1, 1, 1, -1, 1, -1);
    add_frame(-1, -1, -1, 2, 3, 4);
    add_frame(11585, 11585, 0, 0, 0, 0);
    add_frame(0, 32767, -32768, 0, 0, 0);
    add_frame(0, -32768, -32768, 0, 0, 0);
    add_frame(-32768, -32768, 32767, 0, 0, 0);
    add_frame(32767, -1, -32768, 0, 0, 0);
    add_frame(-1, 0, -1, 0, 0, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      frame_t f;
      f.ax = accel_sample(); f.ay = accel_sample(); f.az = accel_sample();
      f.gx = any16(); f.gy = any16(); f.gz = any16();
      pending_frames.push_back(f);
    end
    total_frames = pending_frames.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_frames.size() == 0 && !start);
    wait (tilt_expected.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (tilt_expected.size() != 0) report_mismatch("results missing", 0, tilt_expected.size());

    $display("sent %0d sensor frames (directed extremes plus random), checked %0d results",
             frames_sent, results_seen);
    $display("sender idling at 34%%, 86%% and none; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
